// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/d2d_pkg.sv =====
`timescale 1ns / 1ps

package d2d_pkg;

    // Default sizes of the history buffer and of the longest row.
    localparam int HISTORY_DEPTH_DEF = 128;
    localparam int ROW_WIDTH_MAX_DEF = 4096;

    // Field widths.
    localparam int DEPTH_W   = 8;
    localparam int DIST_W    = 7;
    localparam int DISP_W    = 16;
    localparam int DISP_SHIFT = 9;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_DIST    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_DIST = 1'b1;

    // Register reset values.
    localparam logic [DIST_W-1:0] TOP_DIST_RST    = 7'd64;
    localparam logic [DIST_W-1:0] BOTTOM_DIST_RST = 7'd0;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic step;
        logic load_out;
        logic found;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic last;
        logic hit;
        logic blank;
    } t_sts;

endpackage

// ===== hw/rtl/d2d_ram.sv =====
`timescale 1ns / 1ps

module d2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/d2d_ctrl.sv =====
`timescale 1ns / 1ps

module d2d_ctrl
    import d2d_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // The output register can take a result when empty or when it drains now.
    assign out_free = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (i_sts.empty) begin
                    if (out_free) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (i_sts.hit || i_sts.last) begin
                    if (out_free) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_READ: begin
                if (i_sts.empty && out_free) begin
                    o_cmd.load_out = 1'b1;
                end
            end
            ST_CMP: begin
                if (i_sts.hit || i_sts.last) begin
                    if (out_free) begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.found    = i_sts.hit && !i_sts.blank;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // The output valid flag rises on a load and falls on a transfer.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/d2d_dpath.sv =====
`timescale 1ns / 1ps

module d2d_dpath
    import d2d_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int ROW_WIDTH_MAX = ROW_WIDTH_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIST_W-1:0]    i_cfg_data,
    input  logic [DEPTH_W-1:0]   i_depth_value,
    input  logic                 i_row_start,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic [DISP_W-1:0]    o_disparity,
    output logic                 o_found
);

    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int COL_W = $clog2(ROW_WIDTH_MAX);
    // Wide enough for the column, the last history entry and twice the bottom distance.
    localparam int CMP_W = (COL_W > 11) ? COL_W : 11;
    localparam int ADR_W = PTR_W + 1;

    logic [DIST_W-1:0]  r_max;
    logic [DIST_W-1:0]  r_min;
    logic [DIST_W-1:0]  r_d;
    logic [DIST_W-1:0]  n_d;
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   n_wptr;
    logic [PTR_W-1:0]   r_cur;
    logic [COL_W-1:0]   r_col;
    logic [COL_W-1:0]   n_col;
    logic               r_empty;
    logic               r_blank;
    logic [DISP_W-1:0]  r_disp;
    logic               r_found;

    logic [COL_W-1:0]   col_now;
    logic [CMP_W-1:0]   col_x;
    logic [CMP_W-1:0]   lim_x;
    logic [CMP_W-1:0]   start_x;
    logic               empty_now;
    logic               blank_now;
    logic [ADR_W-1:0]   cur_x;
    logic [ADR_W-1:0]   d_x;
    logic [ADR_W-1:0]   rd_x;
    logic [PTR_W-1:0]   rd_addr;
    logic [DEPTH_W-1:0] hist_q;

    // Configuration writes; the port is always ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= TOP_DIST_RST;
            r_min <= BOTTOM_DIST_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TOP_DIST:    r_max <= i_cfg_data;
                CFG_BOTTOM_DIST: r_min <= i_cfg_data;
                default: begin
                    r_max <= r_max;
                end
            endcase
        end
    end

    // First distance tried is the smallest of the range top, the column and the last entry.
    always_comb begin
        col_now   = i_row_start ? '0 : r_col;
        col_x     = CMP_W'(col_now);
        lim_x     = (CMP_W'(r_max) < col_x) ? CMP_W'(r_max) : col_x;
        start_x   = (lim_x < CMP_W'(HISTORY_DEPTH - 1)) ? lim_x : CMP_W'(HISTORY_DEPTH - 1);
        empty_now = start_x < CMP_W'(r_min);
        blank_now = col_x < (CMP_W'(r_min) << 1);
        n_col     = (col_now < COL_W'(ROW_WIDTH_MAX - 1)) ? col_now + 1'b1 : col_now;
        n_wptr    = (r_wptr == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        n_d       = i_cmd.accept ? start_x[DIST_W-1:0] : r_d - 1'b1;
    end

    // Column counter and write pointer of the circular history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_wptr <= '0;
        end else if (i_cmd.accept) begin
            r_col  <= n_col;
            r_wptr <= n_wptr;
        end
    end

    // Per-item search registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur   <= r_wptr;
            r_empty <= empty_now;
            r_blank <= blank_now;
        end
        if (i_cmd.accept || i_cmd.step) begin
            r_d <= n_d;
        end
    end

    // Entry d back from the current pixel, wrapped around the buffer.
    always_comb begin
        cur_x   = ADR_W'(r_cur);
        d_x     = ADR_W'(r_d);
        rd_x    = (cur_x >= d_x) ? cur_x - d_x : cur_x + ADR_W'(HISTORY_DEPTH) - d_x;
        rd_addr = rd_x[PTR_W-1:0];
    end

    d2d_ram #(
        .WIDTH(DEPTH_W),
        .DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (i_cmd.accept),
        .i_waddr(r_wptr),
        .i_wdata(i_depth_value),
        .i_raddr(rd_addr),
        .o_rdata(hist_q)
    );

    // Status for the controller.
    always_comb begin
        o_sts.empty = r_empty;
        o_sts.last  = (r_d == r_min);
        o_sts.hit   = hist_q >= {1'b0, r_d};
        o_sts.blank = r_blank;
    end

    // Result register; 512 times a 7-bit depth never exceeds the 16-bit limit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_disp  <= i_cmd.found ? {r_d, {DISP_SHIFT{1'b0}}} : '0;
            r_found <= i_cmd.found;
        end
    end

    assign o_disparity = r_disp;
    assign o_found     = r_found;

endmodule

// ===== hw/rtl/depth_to_disparity_row_scan.sv =====
`timescale 1ns / 1ps
// Channel       Direction  Transfer when                  Payload
// s_axis        in         s_axis_tvalid & s_axis_tready  tdata: depth_value; tuser: row_start
// m_axis        out        m_axis_tvalid & m_axis_tready  tdata: disparity; tuser: found
// cfg           in         i_cfg_valid & o_cfg_ready      index, 7-bit register value
//
// A pixel is taken only while the block is idle; its search then tries each depth
// from the top of the range down (1 to HISTORY_DEPTH of them), each try being one read
// of the history RAM and one compare. A pixel whose search range is empty tries none.
// Reset is synchronous and active low; the history RAM needs no clearing.
// A result held in the output register stalls the search only when the next
// result is ready and the register has not been taken.

module depth_to_disparity_row_scan
    import d2d_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int ROW_WIDTH_MAX = ROW_WIDTH_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [DEPTH_W-1:0]   s_axis_tdata,   // [7:0] depth_value
    input  logic                 s_axis_tuser,   // [0] row_start
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [DISP_W-1:0]    m_axis_tdata,   // [15:0] disparity
    output logic                 m_axis_tuser,   // [0] found
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIST_W-1:0]    i_cfg_data
);

`include "assert_macros.svh"

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    d2d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_out_ready(m_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    d2d_dpath #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .ROW_WIDTH_MAX(ROW_WIDTH_MAX)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_depth_value(s_axis_tdata),
        .i_row_start  (s_axis_tuser),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_disparity  (m_axis_tdata),
        .o_found      (m_axis_tuser)
    );

    // A result is loaded only into a free output register.
    `ASSERT_SAME(a_load_free, cmd.load_out, !m_axis_tvalid || m_axis_tready)
    // Accepting a pixel never coincides with finishing one or stepping a search.
    `ASSERT_SAME(a_accept_excl, cmd.accept, !cmd.load_out && !cmd.step)
    // After a pixel is taken the block is busy with its search.
    `ASSERT_NEXT(a_busy_after, cmd.accept, !s_axis_tready)
    // An unmatched or blanked result carries zero disparity.
    `ASSERT_SAME(a_zero_miss, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import d2d_pkg::*;

    localparam int HIST_LEN     = HISTORY_DEPTH_DEF;
    localparam int ROW_LIMIT    = ROW_WIDTH_MAX_DEF;
    localparam int DISP_MAX     = (1 << DISP_W) - 1;
    localparam int N_DIRECTED   = 25;
    localparam int N_PHASES     = 6;
    localparam int PHASE_ITEMS  = 245;
    localparam int DRAIN_CYCLES = 2 * HIST_LEN + 16;

    // Ports of the block.
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [DEPTH_W-1:0]   s_axis_tdata;   // [7:0] depth_value
    logic                 s_axis_tuser;   // [0] row_start
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [DISP_W-1:0]    m_axis_tdata;   // [15:0] disparity
    logic                 m_axis_tuser;   // [0] found
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIST_W-1:0]    i_cfg_data;

    depth_to_disparity_row_scan u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // One expected output transfer.
    typedef struct {
        logic [DISP_W-1:0] disparity;
        logic              found;
    } t_disp_result;

    // One row of the directed table: either a pixel or a new search range.
    typedef struct {
        bit                 is_range;
        logic [DEPTH_W-1:0] depth;     // pixel depth, or the top of the range
        logic [DIST_W-1:0]  bottom;    // bottom of the range
        logic               row_start;
        bit                 given;     // expected result written in the table
        logic [DISP_W-1:0]  disparity;
        logic               found;
    } t_scan_row;

    t_disp_result       disparity_due[$];
    t_scan_row          directed_rows [N_DIRECTED];

    // Shadow of the block: depth line, column counter and search range.
    logic [DEPTH_W-1:0] depth_line [HIST_LEN];
    int                 next_column;
    int                 max_try;
    int                 min_try;

    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 errors;
    int                 pixels_sent;
    int                 results_seen;
    int                 range_writes;

    // Clock.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Computes the disparity of one accepted pixel and advances the shadow.
    function automatic void scan_pixel(input logic [DEPTH_W-1:0] dv, input logic rs,
                                       output t_disp_result res);
        int col;
        int d;
        int v;
        bit done;
        col = rs ? 0 : next_column;
        for (int k = HIST_LEN - 1; k > 0; k--) depth_line[k] = depth_line[k-1];
        depth_line[0] = dv;
        res.disparity = '0;
        res.found = 1'b0;
        done = 1'b0;
        for (d = max_try; d >= min_try && !done; d--) begin
            if (d <= col && d < HIST_LEN && d <= int'(depth_line[d])) begin
                done = 1'b1;
                // A match in the blanked left margin still ends the search.
                if (col >= 2 * min_try) begin
                    v = d << DISP_SHIFT;
                    res.disparity = (v > DISP_MAX) ? DISP_MAX[DISP_W-1:0] : v[DISP_W-1:0];
                    res.found = 1'b1;
                end
            end
        end
        next_column = (col < ROW_LIMIT - 1) ? col + 1 : col;
    endfunction

    // Offers one pixel; called at a falling edge, returns at a falling edge.
    task automatic send_pixel(input logic [DEPTH_W-1:0] dv, input logic rs,
                              input bit given, input t_disp_result given_res);
        t_disp_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= dv;
        s_axis_tuser  <= rs;
        do @(posedge i_clk); while (!s_axis_tready);
        scan_pixel(dv, rs, res);
        disparity_due.push_back(given ? given_res : res);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    // Writes both range registers once the block has gone idle.
    task automatic set_search_range(input logic [DIST_W-1:0] top,
                                    input logic [DIST_W-1:0] bottom);
        s_axis_tvalid <= 1'b0;
        while (disparity_due.size() != 0) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_TOP_DIST;
        i_cfg_data  <= top;
        do @(posedge i_clk); while (!o_cfg_ready);
        max_try = top;
        @(negedge i_clk);
        i_cfg_index <= CFG_BOTTOM_DIST;
        i_cfg_data  <= bottom;
        do @(posedge i_clk); while (!o_cfg_ready);
        min_try = bottom;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        range_writes += 2;
    endtask

    // Picks a search range for a random phase, extremes included.
    task automatic pick_search_range();
        int top;
        int bottom;
        case ($urandom_range(5))
            0: begin
                top = $urandom_range(127);
                bottom = $urandom_range(top);
            end
            1: begin
                top = 127;
                bottom = 0;
            end
            2: begin
                // Empty range: nothing is tried.
                bottom = $urandom_range(127, 1);
                top = $urandom_range(bottom - 1);
            end
            3: begin
                top = $urandom_range(127);
                bottom = top;
            end
            4: begin
                bottom = $urandom_range(120);
                top = bottom + $urandom_range(7);
            end
            default: begin
                bottom = 0;
                top = $urandom_range(16);
            end
        endcase
        set_search_range(top[DIST_W-1:0], bottom[DIST_W-1:0]);
    endtask

    // Sends one row; with noise, row starts go missing or appear mid-row.
    task automatic send_row(input int len, input int style, input bit noise);
        t_disp_result none;
        logic [DEPTH_W-1:0] dv;
        logic rs;
        int c;
        none = '{default: '0};
        for (int i = 0; i < len; i++) begin
            if (i == 0) rs = noise ? ($urandom_range(9) != 0) : 1'b1;
            else rs = noise && ($urandom_range(99) < 2);
            case (style)
                0: dv = DEPTH_W'($urandom_range(255));
                1: dv = DEPTH_W'($urandom_range(15));
                default: begin
                    // Depths close to the searched ones, so matches come and go.
                    c = max_try - 4 + $urandom_range(8);
                    dv = (c < 0) ? 8'd0 : c[DEPTH_W-1:0];
                end
            endcase
            send_pixel(dv, rs, 1'b0, none);
        end
    endtask

    // Receiver stalls, decided at each falling edge.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compares each output transfer with the oldest expected result.
    always @(posedge i_clk) begin
        t_disp_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (disparity_due.size() == 0) begin
                $error("unexpected result: disparity %0d found %0d",
                       m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                want = disparity_due.pop_front();
                if (m_axis_tdata !== want.disparity) begin
                    $error("disparity: expected %0d, got %0d", want.disparity, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // Run limit.
    initial begin
        #40_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // Stimulus.
    initial begin
        t_disp_result given_res;
        int n;

        // Directed table: after reset the range is 0 to 64.
        directed_rows = '{
            '{0, 8'd0,   7'd0,   1'b0, 1, 16'd0,   1'b1},  // no row start after reset
            '{0, 8'd255, 7'd0,   1'b0, 1, 16'd0,   1'b1},
            '{0, 8'd255, 7'd0,   1'b0, 1, 16'd512, 1'b1},
            '{0, 8'd200, 7'd0,   1'b0, 0, 16'd0,   1'b0},
            '{0, 8'd1,   7'd0,   1'b1, 1, 16'd0,   1'b1},  // left edge: only zero fits
            '{0, 8'd3,   7'd0,   1'b0, 0, 16'd0,   1'b0},
            '{1, 8'd127, 7'd127, 1'b0, 0, 16'd0,   1'b0},
            '{0, 8'd255, 7'd0,   1'b1, 1, 16'd0,   1'b0},
            '{0, 8'd128, 7'd0,   1'b0, 1, 16'd0,   1'b0},
            '{1, 8'd5,   7'd10,  1'b0, 0, 16'd0,   1'b0},  // empty range
            '{0, 8'd255, 7'd0,   1'b0, 1, 16'd0,   1'b0},
            '{0, 8'd0,   7'd0,   1'b1, 1, 16'd0,   1'b0},
            '{1, 8'd1,   7'd1,   1'b0, 0, 16'd0,   1'b0},
            '{0, 8'd9,   7'd0,   1'b1, 1, 16'd0,   1'b0},
            '{0, 8'd7,   7'd0,   1'b0, 1, 16'd0,   1'b0},  // match inside the blanked margin
            '{0, 8'd0,   7'd0,   1'b0, 0, 16'd0,   1'b0},
            '{0, 8'd0,   7'd0,   1'b0, 0, 16'd0,   1'b0},
            '{1, 8'd0,   7'd0,   1'b0, 0, 16'd0,   1'b0},
            '{0, 8'd0,   7'd0,   1'b1, 1, 16'd0,   1'b1},
            '{0, 8'd170, 7'd0,   1'b0, 1, 16'd0,   1'b1},
            '{1, 8'd127, 7'd0,   1'b0, 0, 16'd0,   1'b0},
            '{0, 8'd85,  7'd0,   1'b1, 0, 16'd0,   1'b0},
            '{0, 8'd255, 7'd0,   1'b0, 0, 16'd0,   1'b0},
            '{0, 8'd127, 7'd0,   1'b0, 0, 16'd0,   1'b0},
            '{0, 8'd128, 7'd0,   1'b0, 0, 16'd0,   1'b0}
        };

        // Known values on every input, then reset.
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_TOP_DIST;
        i_cfg_data    = '0;
        errors        = 0;
        pixels_sent   = 0;
        results_seen  = 0;
        range_writes  = 0;
        send_idle_pct = 6;
        recv_idle_pct = 45;
        for (int k = 0; k < HIST_LEN; k++) depth_line[k] = '0;
        next_column = 0;
        max_try = TOP_DIST_RST;
        min_try = BOTTOM_DIST_RST;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_range) begin
                set_search_range(directed_rows[r].depth[DIST_W-1:0], directed_rows[r].bottom);
            end else begin
                given_res.disparity = directed_rows[r].disparity;
                given_res.found = directed_rows[r].found;
                send_pixel(directed_rows[r].depth, directed_rows[r].row_start,
                           directed_rows[r].given, given_res);
            end
        end

        // Random phases: slow receiver, then slow sender, then no stalls.
        for (int p = 0; p < N_PHASES; p++) begin
            if (p < N_PHASES / 3) begin
                send_idle_pct = 6;
                recv_idle_pct = 45;
            end else if (p < 2 * N_PHASES / 3) begin
                send_idle_pct = 45;
                recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick_search_range();
            n = 0;
            while (n < PHASE_ITEMS) begin
                int len;
                len = $urandom_range(300, 1);
                if (len > PHASE_ITEMS - n) len = PHASE_ITEMS - n;
                send_row(len, $urandom_range(2), 1'b1);
                n += len;
            end
        end

        // Drain.
        s_axis_tvalid <= 1'b0;
        while (disparity_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d pixels and checked %0d results over %0d range register writes,",
                 pixels_sent, results_seen, range_writes);
        $display("covering empty, blanked, full and narrow search ranges under three stall mixes.");
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/d2d_pkg.sv
hw/rtl/d2d_ram.sv
hw/rtl/d2d_ctrl.sv
hw/rtl/d2d_dpath.sv
hw/rtl/depth_to_disparity_row_scan.sv
test/testbench.sv
